/* hdl/aei_pkg.sv */
// Package for the arithmetic interval encoder: item types, controller states
// and the command and status structs between controller and datapath.
// Depends on nothing; every other file of the block uses it.
package aei_pkg;

    localparam int LOWER_W     = 16;
    localparam int UPPER_W     = 17;
    localparam int RUN_W       = 16;
    localparam int MAX_RESULTS = 18;
    localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);

    localparam logic [RUN_W-1:0] PENDING_MAX = {RUN_W{1'b1}};

    typedef struct packed {
        logic [UPPER_W-1:0] upper_cum;
        logic [LOWER_W-1:0] lower_cum;
    } in_item_t;

    typedef struct packed {
        logic             code_bit;
        logic [RUN_W-1:0] follow_run;
        logic             last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_NARROW,
        ST_RENORM,
        ST_FLUSH
    } aei_state_t;

    typedef struct packed {
        logic load;
        logic mul_lo;
        logic mul_hi;
        logic narrow;
        logic emit;
        logic straddle;
        logic flush;
    } aei_cmd_t;

    typedef struct packed {
        logic emit_cond;
        logic straddle_cond;
        logic count_full;
        logic held_valid;
        logic out_free;
    } aei_status_t;

endpackage

/* hdl/aei_ctrl.sv */
// Controller of the arithmetic interval encoder: sequences load, the two
// multiplications, narrowing, renormalisation and the final flush.
// Depends on aei_pkg.
module aei_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sym_valid,
    output logic                sym_ready,
    input  aei_pkg::aei_status_t status,
    output aei_pkg::aei_cmd_t    cmd
);

    aei_pkg::aei_state_t state_reg;
    aei_pkg::aei_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aei_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        sym_ready  = 1'b0;
        unique case (state_reg)
            aei_pkg::ST_IDLE:
            begin
                sym_ready = 1'b1;
                if (sym_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = aei_pkg::ST_MUL_LO;
                end
            end
            aei_pkg::ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = aei_pkg::ST_MUL_HI;
            end
            aei_pkg::ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = aei_pkg::ST_NARROW;
            end
            aei_pkg::ST_NARROW:
            begin
                cmd.narrow = 1'b1;
                state_next = aei_pkg::ST_RENORM;
            end
            aei_pkg::ST_RENORM:
            begin
                if (status.emit_cond)
                begin
                    // Once the result budget is spent the interval is left as it is.
                    if (status.count_full)
                    begin
                        state_next = aei_pkg::ST_FLUSH;
                    end
                    else if (!status.held_valid || status.out_free)
                    begin
                        cmd.emit = 1'b1;
                    end
                end
                else if (status.straddle_cond)
                begin
                    cmd.straddle = 1'b1;
                end
                else
                begin
                    state_next = aei_pkg::ST_FLUSH;
                end
            end
            aei_pkg::ST_FLUSH:
            begin
                if (!status.held_valid)
                begin
                    state_next = aei_pkg::ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = aei_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = aei_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/aei_datapath.sv */
// Datapath of the arithmetic interval encoder: interval and pending state,
// the shared range multiplier, the renormalising shifter and the result register.
// Depends on aei_pkg.
module aei_datapath
#(
    parameter int CODE_BITS = 32,
    parameter int PROB_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  aei_pkg::in_item_t    sym,
    input  aei_pkg::aei_cmd_t    cmd,
    output aei_pkg::aei_status_t status,
    output aei_pkg::out_item_t   res,
    output logic                 res_valid,
    input  logic                 res_ready
);

    localparam int UW = aei_pkg::UPPER_W;
    localparam int RW = CODE_BITS + 1;
    localparam int OW = PROB_BITS + 1;
    localparam int PW = RW + OW;

    localparam logic [UW-1:0] PMAX    = UW'(1 << PROB_BITS);
    localparam logic [UW-1:0] PMAX_M1 = PMAX - UW'(1);

    logic [CODE_BITS-1:0]          lo_reg, lo_next;
    logic [CODE_BITS-1:0]          hi_reg, hi_next;
    logic [aei_pkg::RUN_W-1:0]     pending_reg, pending_next;
    logic [CODE_BITS-1:0]          nlo_reg;
    logic [RW-1:0]                 range_reg;
    logic [PW-1:0]                 prod_reg;
    logic [PROB_BITS-1:0]          lo_c_reg;
    logic [PROB_BITS:0]            up_c_reg;
    logic [aei_pkg::COUNT_W-1:0]   count_reg;
    logic                          held_valid_reg;
    logic                          held_bit_reg;
    logic [aei_pkg::RUN_W-1:0]     held_run_reg;
    logic                          res_valid_reg;
    aei_pkg::out_item_t            res_reg;

    logic [UW-1:0]        lo_clamp, up_clamp, up_fix;
    logic [CODE_BITS-1:0] hi_eff;
    logic [RW-1:0]        range_new;
    logic [OW-1:0]        mul_op;
    logic [RW-1:0]        quot;
    logic [RW-1:0]        upper_sum, upper_sum_m1;
    logic [CODE_BITS-1:0] nhi;
    logic                 out_free;
    logic                 push;

    // Bounds are limited to the probability scale and an empty symbol widened by one.
    always_comb
    begin
        lo_clamp = ({1'b0, sym.lower_cum} > PMAX_M1) ? PMAX_M1 : {1'b0, sym.lower_cum};
        up_clamp = (sym.upper_cum > PMAX) ? PMAX : sym.upper_cum;
        up_fix   = (up_clamp <= lo_clamp) ? lo_clamp + UW'(1) : up_clamp;
        hi_eff   = (hi_reg < lo_reg) ? lo_reg : hi_reg;
        range_new = {1'b0, hi_eff} - {1'b0, lo_reg} + RW'(1);
    end

    assign mul_op = cmd.mul_hi ? up_c_reg : {1'b0, lo_c_reg};
    assign quot   = prod_reg[PROB_BITS +: RW];

    // A zero upper sum wraps to all ones rather than collapsing onto the low bound.
    always_comb
    begin
        upper_sum    = {1'b0, lo_reg} + quot;
        upper_sum_m1 = upper_sum - RW'(1);
        if (upper_sum == '0)
        begin
            nhi = {CODE_BITS{1'b1}};
        end
        else if (upper_sum_m1[CODE_BITS-1:0] < nlo_reg)
        begin
            nhi = nlo_reg;
        end
        else
        begin
            nhi = upper_sum_m1[CODE_BITS-1:0];
        end
    end

    always_comb
    begin
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        pending_next = pending_reg;
        if (cmd.narrow)
        begin
            lo_next = nlo_reg;
            hi_next = nhi;
        end
        else if (cmd.emit)
        begin
            lo_next      = {lo_reg[CODE_BITS-2:0], 1'b0};
            hi_next      = {hi_reg[CODE_BITS-2:0], 1'b1};
            pending_next = '0;
        end
        else if (cmd.straddle)
        begin
            // Removing a quarter maps 01 to 00 and 10 to 01; the shift drops the top.
            lo_next = {1'b0, lo_reg[CODE_BITS-3:0], 1'b0};
            hi_next = {1'b1, hi_reg[CODE_BITS-3:0], 1'b1};
            if (pending_reg != aei_pkg::PENDING_MAX)
            begin
                pending_next = pending_reg + aei_pkg::RUN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg         <= '0;
            hi_reg         <= {CODE_BITS{1'b1}};
            pending_reg    <= '0;
            count_reg      <= '0;
            held_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            pending_reg <= pending_next;
            if (cmd.narrow)
            begin
                count_reg <= '0;
            end
            else if (cmd.emit)
            begin
                count_reg <= count_reg + aei_pkg::COUNT_W'(1);
            end
            if (cmd.emit)
            begin
                held_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                held_valid_reg <= 1'b0;
            end
            if (push)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lo_c_reg  <= lo_clamp[PROB_BITS-1:0];
            up_c_reg  <= up_fix[PROB_BITS:0];
            range_reg <= range_new;
        end
        if (cmd.mul_lo || cmd.mul_hi)
        begin
            prod_reg <= PW'(range_reg) * PW'(mul_op);
        end
        if (cmd.mul_hi)
        begin
            nlo_reg <= lo_reg + quot[CODE_BITS-1:0];
        end
        if (cmd.emit)
        begin
            held_bit_reg <= hi_reg[CODE_BITS-1];
            held_run_reg <= pending_reg;
        end
        if (push)
        begin
            res_reg.code_bit   <= held_bit_reg;
            res_reg.follow_run <= held_run_reg;
            res_reg.last       <= cmd.flush;
        end
    end

    // The held item goes out once the next emission or the end of the symbol is known.
    assign push     = held_valid_reg && (cmd.emit || cmd.flush);
    assign out_free = !res_valid_reg || res_ready;

    assign status.emit_cond     = !hi_reg[CODE_BITS-1] || lo_reg[CODE_BITS-1];
    assign status.straddle_cond = (lo_reg[CODE_BITS-1:CODE_BITS-2] == 2'b01)
                               && (hi_reg[CODE_BITS-1:CODE_BITS-2] == 2'b10);
    assign status.count_full    = (count_reg >= aei_pkg::COUNT_W'(aei_pkg::MAX_RESULTS));
    assign status.held_valid    = held_valid_reg;
    assign status.out_free      = out_free;

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

endmodule

/* hdl/arith_encode_interval.sv */
// Top level of the arithmetic interval encoder: controller and datapath.
// Depends on aei_pkg, aei_ctrl and aei_datapath.
//
//  channel  | valid     | ready     | payload             | moves
//  ---------+-----------+-----------+---------------------+------------------------
//  symbol   | sym_valid | sym_ready | sym (in_item_t)     | cumulative bounds in
//  result   | res_valid | res_ready | res (out_item_t)    | code bit and run out
//
// An item passes through the accept state, two steps on the shared range
// multiplier, one narrowing step, one renormalising step per shift, one that
// finds no further shift and one to close the symbol; a new symbol is taken
// only once the previous one is closed.
// Reset puts the interval at its full span with no pending bits; no clearing pass.
// A stalled result register holds the renormaliser before its next emission.
module arith_encode_interval
#(
    parameter int CODE_BITS = 32,
    parameter int PROB_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sym_valid,
    output logic               sym_ready,
    input  aei_pkg::in_item_t  sym,
    output logic               res_valid,
    input  logic               res_ready,
    output aei_pkg::out_item_t res
);

    aei_pkg::aei_cmd_t    cmd;
    aei_pkg::aei_status_t status;

    aei_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (sym_valid),
        .sym_ready (sym_ready),
        .status    (status),
        .cmd       (cmd)
    );

    aei_datapath
    #(
        .CODE_BITS (CODE_BITS),
        .PROB_BITS (PROB_BITS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym       (sym),
        .cmd       (cmd),
        .status    (status),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready)
    );

endmodule
